[design/pol_pkg.sv]
package pol_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 7;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int TDATA_W  = 48;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_DRAIN,
      S_PLACE,
      S_FETCH,
      S_CAPTURE,
      S_DONE
   } state_type;

endpackage

[design/pol_ram.sv]
module pol_ram #(
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [ADDR_W-1:0]          waddr,
   input  logic [pol_pkg::WORD_W-1:0] wdata,
   input  logic [ADDR_W-1:0]          raddr,
   output logic [pol_pkg::WORD_W-1:0] rdata
);
   import pol_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/pol_seq.sv]
module pol_seq #(
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pol_pkg::OP_W-1:0]            req_op,
   input  logic [pol_pkg::POS_W-1:0]           req_position,
   input  logic signed [pol_pkg::WORD_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pol_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [pol_pkg::WORD_W-1:0]   rsp_read_data,
   output logic [pol_pkg::POS_W-1:0]           rsp_length,
   output logic                                mem_we,
   output logic [ADDR_W-1:0]                   mem_waddr,
   output logic [pol_pkg::WORD_W-1:0]          mem_wdata,
   output logic [ADDR_W-1:0]                   mem_raddr,
   input  logic [pol_pkg::WORD_W-1:0]          mem_rdata
);
   import pol_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [WORD_W-1:0]   value_ff, value_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   end_ff, end_in;
   logic                wvld_ff, wvld_in;
   logic [ADDR_W-1:0]   wdst_ff, wdst_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [WORD_W-1:0]   data_ff, data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]    rsp_length_ff, rsp_length_in;

   logic              accept;
   logic              out_free;
   logic [CMP_W-1:0]  pos_x;
   logic [CMP_W-1:0]  cnt_x;
   logic              is_full;
   logic              in_list;
   logic              at_tail;
   logic              at_last;
   logic              dir_up;
   logic [ADDR_W-1:0] src_addr;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign pos_x    = CMP_W'(req_position);
   assign cnt_x    = CMP_W'(count_ff);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign in_list  = (pos_x < cnt_x);
   assign at_tail  = (pos_x == cnt_x);
   assign at_last  = (pos_x + CMP_W'(1) == cnt_x);
   assign dir_up   = (op_ff == OP_INSERT);
   assign src_addr = dir_up ? (idx_ff - ADDR_W'(1)) : (idx_ff + ADDR_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DONE;
               if (req_op == OP_INSERT && (in_list || at_tail) && !is_full) begin
                  state_in = at_tail ? S_PLACE : S_SHIFT;
               end else if (req_op == OP_REMOVE && in_list && !at_last) begin
                  state_in = S_SHIFT;
               end else if (req_op == OP_READ && in_list) begin
                  state_in = S_FETCH;
               end
            end
         end
         S_SHIFT: begin
            if (idx_ff == end_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN:   state_in = dir_up ? S_PLACE : S_DONE;
         S_PLACE:   state_in = S_DONE;
         S_FETCH:   state_in = S_CAPTURE;
         S_CAPTURE: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      wvld_in       = (state_ff == S_SHIFT);
      wdst_in       = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_length_in = rsp_length_ff;
      mem_we        = 1'b0;
      mem_waddr     = wdst_ff;
      mem_wdata     = mem_rdata;
      mem_raddr     = (state_ff == S_FETCH) ? pos_ff : src_addr;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               pos_in    = ADDR_W'(req_position);
               value_in  = req_value;
               data_in   = '0;
               status_in = ST_RANGE;
               if (req_op == OP_INSERT) begin
                  idx_in = ADDR_W'(count_ff);
                  end_in = ADDR_W'(req_position) + ADDR_W'(1);
                  if (in_list || at_tail) begin
                     status_in = is_full ? ST_FULL : ST_OK;
                  end
               end else begin
                  idx_in = ADDR_W'(req_position);
                  end_in = ADDR_W'(count_ff) - ADDR_W'(2);
                  if ((req_op == OP_REMOVE || req_op == OP_READ) && in_list) begin
                     status_in = ST_OK;
                  end
               end
            end
         end
         S_SHIFT: begin
            idx_in = src_addr;
         end
         S_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = value_ff;
         end
         S_CAPTURE: begin
            data_in = mem_rdata;
         end
         S_DONE: begin
            if (out_free) begin
               if (status_ff == ST_OK && op_ff == OP_INSERT) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (status_ff == ST_OK && op_ff == OP_REMOVE) begin
                  count_in = count_ff - CNT_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = data_ff;
               rsp_length_in = POS_W'(count_in);
            end
         end
         default: begin
         end
      endcase

      if (wvld_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wvld_ff      <= wvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      wdst_ff       <= wdst_in;
      status_ff     <= status_in;
      data_ff       <= data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_length    = rsp_length_ff;

endmodule

[design/positional_ordered_list.sv]
// Bounded ordered list of up to DEPTH signed 32-bit words held in a single-port-write,
// registered-read memory. Each request transfer inserts, removes or reads at a position
// and yields exactly one result transfer with status, read data and the new length.
// Entries are moved one per cycle through the memory, one step per entry between the
// position and the tail: an insert shifts and then writes the value (an append only
// writes it), a remove shifts (removing the last entry needs no shift), a read fetches
// and then captures the word, and a rejected request goes straight to the result. The
// block is not ready while a request is in progress and is ready again in the same
// cycle as the result appears, but a finished result waits in the output register while
// the next request is accepted. No clearing pass is needed after reset.
module positional_ordered_list #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // op [1:0], position [8:2], value [40:9], zero fill above
   input  logic [pol_pkg::TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status [1:0], read_data [33:2], length [40:34], zero fill above
   output logic [pol_pkg::TDATA_W-1:0] rsp_tdata
);
   import pol_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RSP_W  = STATUS_W + WORD_W + POS_W;

   logic [OP_W-1:0]          req_op;
   logic [POS_W-1:0]         req_position;
   logic signed [WORD_W-1:0] req_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [WORD_W-1:0] rsp_read_data;
   logic [POS_W-1:0]         rsp_length;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [WORD_W-1:0]        mem_wdata;
   logic [ADDR_W-1:0]        mem_raddr;
   logic [WORD_W-1:0]        mem_rdata;

   assign req_op       = req_tdata[OP_W-1:0];
   assign req_position = req_tdata[OP_W+POS_W-1:OP_W];
   assign req_value    = req_tdata[OP_W+POS_W+WORD_W-1:OP_W+POS_W];

   assign rsp_tdata = {{(TDATA_W-RSP_W){1'b0}}, rsp_length, rsp_read_data, rsp_status};

   pol_seq #(
      .DEPTH(DEPTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_read_data (rsp_read_data),
      .rsp_length    (rsp_length),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata)
   );

   pol_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule
